/* rtl/tms_pkg.sv */
// ----------------------------------------------------------------------------
// tms_pkg
// types, codes and helper functions shared by the torus modulus switch unit
// ----------------------------------------------------------------------------
package tms_pkg;

	localparam int unsigned WORD_W    = 32;
	localparam int unsigned WIDE_W    = 64;
	localparam int unsigned MOD_W     = 31;
	localparam int unsigned DIV_STEPS = 32;

	localparam logic [1:0] ACT_ENCODE = 2'd0;
	localparam logic [1:0] ACT_ROUND  = 2'd1;
	localparam logic [1:0] ACT_DECODE = 2'd2;

	localparam logic [MOD_W-1:0]  MOD_RESET = 31'd16;
	localparam logic [MOD_W-1:0]  MOD_MIN   = 31'd2;
	localparam logic [WIDE_W-1:0] IV_RESET  = 64'h1000_0000_0000_0000;

	typedef struct packed {
		logic [1:0]         action;
		logic signed [31:0] message;
		logic signed [31:0] phase_in;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] result;
	} rsp_t;

	typedef struct packed {
		logic [MOD_W-1:0] modulus;
	} cfg_t;

	typedef struct packed {
		logic [1:0]        action;
		logic [WIDE_W-1:0] x;
		logic [WIDE_W-1:0] rem;
		logic [WORD_W-1:0] quo;
		logic [WORD_W-1:0] enc;
	} div_t;

	typedef struct packed {
		logic [WIDE_W-1:0] rem;
		logic              qbit;
	} step_t;

	// one restoring division step: shift in a dividend bit, subtract if it fits
	function automatic step_t div_step(input logic [WIDE_W-1:0] rem,
		input logic din, input logic [WIDE_W-1:0] divisor);
		logic [WIDE_W:0] t;
		step_t           s;
		t = {rem, din};
		if (t >= {1'b0, divisor}) begin
			s.rem  = WIDE_W'(t - {1'b0, divisor});
			s.qbit = 1'b1;
		end else begin
			s.rem  = t[WIDE_W-1:0];
			s.qbit = 1'b0;
		end
		return s;
	endfunction

endpackage

/* rtl/tms_stream_if.sv */
// ----------------------------------------------------------------------------
// tms_stream_if
// valid/ready channel carrying one payload per transfer
// ----------------------------------------------------------------------------
interface tms_stream_if #(parameter type data_t = logic);
	logic  valid;
	logic  ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/torus_modulus_switch_unit.sv */
// ----------------------------------------------------------------------------
// torus_modulus_switch_unit
// encode, round and decode between a 32-bit torus and Z/pZ
// ----------------------------------------------------------------------------
// The unit takes one item per clock unless stalled or dividing for a modulus
// write, and passes it through one front stage with the encode multipliers and
// phase placement, 32 stages of a one-bit-per-stage restoring divider by the
// interval width, and one output stage. Stalls on the result side hold the
// pipeline without loss; empty stages still fill, so items keep being taken
// until every stage holds one. A modulus write starts a serial division
// deriving the interval width, during which neither items nor further writes
// are taken. After reset the modulus is 16 and the unit is ready at once.
module torus_modulus_switch_unit
	import tms_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	tms_stream_if.sink    cmd,
	tms_stream_if.source  rsp,
	tms_stream_if.sink    cfg
);

	localparam int unsigned LAST = DIV_STEPS + 1;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_DIV  = 1'b1;

	// interval width computation
	logic              state_q;
	logic [MOD_W-1:0]  mod_q;
	logic [MOD_W-1:0]  irem_q;
	logic [62:0]       iquo_q;
	logic [5:0]        icnt_q;
	logic [WIDE_W-1:0] iv_q;
	logic [MOD_W:0]    it;
	logic              iqbit;
	logic [62:0]       iquo_next;
	logic [MOD_W-1:0]  wr_mod;

	assign cfg.ready = (state_q == ST_IDLE);
	assign wr_mod    = (cfg.data.modulus < MOD_MIN) ? MOD_MIN : cfg.data.modulus;
	assign it        = {irem_q, (icnt_q == 6'd0)};
	assign iqbit     = (it >= {1'b0, mod_q});
	assign iquo_next = {iquo_q[61:0], iqbit};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mod_q   <= MOD_RESET;
			iv_q    <= IV_RESET;
			icnt_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cfg.valid) begin
						mod_q   <= wr_mod;
						icnt_q  <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					icnt_q <= icnt_q + 6'd1;
					if (icnt_q == 6'd63) begin
						iv_q    <= {iquo_next, 1'b0};
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			irem_q <= '0;
			iquo_q <= '0;
		end else begin
			irem_q <= iqbit ? MOD_W'(it - {1'b0, mod_q}) : it[MOD_W-1:0];
			iquo_q <= iquo_next;
		end
	end

	// pipeline flow control
	logic [LAST:0] vld_q;
	logic [LAST:0] rdy;

	genvar g;
	generate
		for (g = 0; g <= LAST; g++) begin : g_rdy
			assign rdy[g] = rsp.ready || !(&vld_q[LAST:g]);
		end
	endgenerate

	assign cmd.ready = rdy[0] && (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[0])
				vld_q[0] <= cmd.valid && cmd.ready;
			for (int k = 1; k <= LAST; k++) begin
				if (rdy[k])
					vld_q[k] <= vld_q[k-1];
			end
		end
	end

	// front stage: partial products and phase placement
	logic [1:0]         act_s1;
	logic [WIDE_W-1:0]  x_s1;
	logic [WORD_W-1:0]  plo_s1;
	logic [WORD_W-1:0]  phi_s1;
	logic signed [64:0] prod_lo;
	logic [WORD_W-1:0]  prod_hi;

	assign prod_lo = $signed(cmd.data.message) * $signed({1'b0, iv_q[31:0]});
	assign prod_hi = cmd.data.message * iv_q[63:32];

	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			act_s1 <= cmd.data.action;
			x_s1   <= {cmd.data.phase_in, 32'd0} + {1'b0, iv_q[WIDE_W-1:1]};
			plo_s1 <= prod_lo[63:32];
			phi_s1 <= prod_hi;
		end
	end

	// divider stages, one quotient bit each
	div_t  div_s2 [DIV_STEPS];
	div_t  div_in [DIV_STEPS];
	step_t div_st [DIV_STEPS];

	generate
		for (g = 0; g < DIV_STEPS; g++) begin : g_div
			if (g == 0) begin : g_first
				assign div_in[g].action = act_s1;
				assign div_in[g].x      = x_s1;
				assign div_in[g].rem    = {32'd0, x_s1[63:32]};
				assign div_in[g].quo    = '0;
				assign div_in[g].enc    = plo_s1 + phi_s1;
			end else begin : g_rest
				assign div_in[g] = div_s2[g-1];
			end
			assign div_st[g] = div_step(div_in[g].rem, div_in[g].x[DIV_STEPS-1-g], iv_q);
			always_ff @(posedge clk) begin
				if (rdy[g+1]) begin
					div_s2[g].action <= div_in[g].action;
					div_s2[g].x      <= div_in[g].x;
					div_s2[g].enc    <= div_in[g].enc;
					div_s2[g].rem    <= div_st[g].rem;
					div_s2[g].quo    <= {div_in[g].quo[WORD_W-2:0], div_st[g].qbit};
				end
			end
		end
	endgenerate

	// output stage
	div_t              fin;
	logic [WIDE_W-1:0] rnd_full;
	logic [WORD_W-1:0] half;
	logic [WORD_W-1:0] dec;
	logic [WORD_W-1:0] res_d;
	logic [WORD_W-1:0] res_s3;

	assign fin      = div_s2[DIV_STEPS-1];
	assign rnd_full = fin.x - fin.rem;
	assign half     = {2'b00, mod_q[MOD_W-1:1]};
	assign dec      = ($signed(fin.quo) >= $signed(half)) ? fin.quo - {1'b0, mod_q} : fin.quo;

	always_comb begin
		case (fin.action)
			ACT_ENCODE: res_d = fin.enc;
			ACT_ROUND:  res_d = rnd_full[63:32];
			ACT_DECODE: res_d = dec;
			default:    res_d = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rdy[LAST])
			res_s3 <= res_d;
	end

	assign rsp.valid       = vld_q[LAST];
	assign rsp.data.result = res_s3;

endmodule

/* rtl/tms_checker.sv */
// ----------------------------------------------------------------------------
// tms_checker
// port-level checks for the torus modulus switch unit
// ----------------------------------------------------------------------------
module tms_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cmd_ready,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [31:0] rsp_result
);

	// a modulus write blocks items while the interval is recomputed
	a_cfg_blocks_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> !cmd_ready)
		else $error("item taken right after a modulus write");

	a_cfg_blocks_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> !cfg_ready)
		else $error("second modulus write taken during recompute");

	// items are only taken when the config side is idle
	a_cmd_needs_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_ready |-> cfg_ready)
		else $error("item ready while interval recompute is running");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result))
		else $error("stalled result changed or dropped");

endmodule

bind torus_modulus_switch_unit tms_checker u_tms_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.cmd_ready  (cmd.ready),
	.cfg_valid  (cfg.valid),
	.cfg_ready  (cfg.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_result (rsp.data.result)
);
